FILE: sv/chacha20_stream_cipher_core_defines.svh
// Assertion macros shared by the ChaCha20 stream cipher core.
`ifndef CHACHA20_STREAM_CIPHER_CORE_DEFINES_SVH
`define CHACHA20_STREAM_CIPHER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication: whenever ante holds, cons holds in that cycle.
`define CHACHA_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chacha20 core: implication check failed");
// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define CHACHA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chacha20 core: next-cycle check failed");
`else
`define CHACHA_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define CHACHA_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/chacha_pkg.sv
// Types and constants shared by the ChaCha20 stream cipher modules.
package chacha_pkg;

    typedef logic [31:0]       t_word;
    typedef logic [15:0][31:0] t_block;
    typedef logic [7:0][31:0]  t_key;
    typedef logic [2:0][31:0]  t_nonce;

    localparam t_word SIGMA0 = 32'h6170_7865;
    localparam t_word SIGMA1 = 32'h3320_646e;
    localparam t_word SIGMA2 = 32'h7962_2d32;
    localparam t_word SIGMA3 = 32'h6b20_6574;

    localparam int BLOCK_BYTES = 64;
    localparam int POS_W       = 6;
    localparam int HALF_STEPS  = 40;
    localparam int STEP_W      = 6;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_01    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_23    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_45    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_67    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_01  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_2   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_CTR = 3'd6;

    // One classified byte as it travels from the front part to the back part.
    typedef struct packed {
        logic [7:0]       data;
        logic             last;
        logic [POS_W-1:0] pos;
        logic             first;
    } t_qentry;

    typedef struct packed {
        logic  valid;
        t_word ctr;
    } t_ks_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_ks_status;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
    } t_quad;

endpackage

FILE: sv/chacha_fifo.sv
// Short queue of classified bytes between the front and back parts.
module chacha_fifo
    import chacha_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_qentry i_wr_data,
    output logic    o_full,
    input  logic    i_rd,
    output logic    o_rd_valid,
    output t_qentry o_rd_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_qentry            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (!i_wr && i_rd) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

FILE: sv/chacha_front.sv
// Input side: takes bytes and tags each with its block position and message start.
module chacha_front
    import chacha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_data,
    input  logic       i_last,
    input  logic       i_q_full,
    output logic       o_wr,
    output t_qentry    o_wr_data
);

    logic [POS_W-1:0] r_pos;
    logic             r_msg_start;
    logic [POS_W-1:0] cur_pos;

    assign o_full  = i_q_full;
    assign o_wr    = i_push && !i_q_full;
    assign cur_pos = r_msg_start ? '0 : r_pos;

    always_comb begin
        o_wr_data.data  = i_data;
        o_wr_data.last  = i_last;
        o_wr_data.pos   = cur_pos;
        o_wr_data.first = r_msg_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_msg_start <= 1'b1;
        end else if (o_wr) begin
            if (i_last) begin
                r_pos       <= '0;
                r_msg_start <= 1'b1;
            end else begin
                r_pos       <= cur_pos + 1'b1;
                r_msg_start <= 1'b0;
            end
        end
    end

endmodule

FILE: sv/chacha_keygen.sv
// Keystream block generator: one half of a ChaCha20 round per cycle, then the final add.
module chacha_keygen
    import chacha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_key       i_key,
    input  t_nonce     i_nonce,
    input  t_ks_req    i_req,
    output t_ks_status o_status,
    output t_block     o_block
);

    function automatic t_block load_state(t_key key, t_nonce nonce, t_word ctr);
        t_block s;
        s[0]     = SIGMA0;
        s[1]     = SIGMA1;
        s[2]     = SIGMA2;
        s[3]     = SIGMA3;
        s[11:4]  = key;
        s[12]    = ctr;
        s[15:13] = nonce;
        return s;
    endfunction

    // First half rotates by 16 and 12, second half by 8 and 7.
    function automatic t_quad qr_half(t_quad q, logic second);
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word t;
        a = q.a + q.b;
        t = q.d ^ a;
        d = second ? {t[23:0], t[31:24]} : {t[15:0], t[31:16]};
        c = q.c + d;
        t = q.b ^ c;
        b = second ? {t[24:0], t[31:25]} : {t[19:0], t[31:20]};
        return t_quad'{a, b, c, d};
    endfunction

    t_block            r_x;
    t_word             r_ctr;
    logic              r_busy;
    logic              r_fin;
    logic [STEP_W-1:0] r_step;

    t_block n_round;
    t_block fin_init;
    t_quad  lane_in  [4];
    t_quad  lane_out [4];
    logic   diag;
    logic   second;

    assign diag   = r_step[1];
    assign second = r_step[0];

    for (genvar g = 0; g < 4; g++) begin : g_lane
        localparam int BD = 4 + ((g + 1) % 4);
        localparam int CD = 8 + ((g + 2) % 4);
        localparam int DD = 12 + ((g + 3) % 4);
        localparam int LB = (g + 3) % 4;
        localparam int LC = (g + 2) % 4;
        localparam int LD = (g + 1) % 4;

        assign lane_in[g] = diag ? t_quad'{r_x[g], r_x[BD], r_x[CD], r_x[DD]}
                                 : t_quad'{r_x[g], r_x[4+g], r_x[8+g], r_x[12+g]};
        assign lane_out[g] = qr_half(lane_in[g], second);

        assign n_round[g]    = lane_out[g].a;
        assign n_round[4+g]  = diag ? lane_out[LB].b : lane_out[g].b;
        assign n_round[8+g]  = diag ? lane_out[LC].c : lane_out[g].c;
        assign n_round[12+g] = diag ? lane_out[LD].d : lane_out[g].d;
    end

    assign fin_init = load_state(i_key, i_nonce, r_ctr);

    for (genvar j = 0; j < 16; j++) begin : g_ffwd
        assign o_block[j] = r_x[j] + fin_init[j];
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_step <= '0;
        end else if (!r_busy) begin
            r_busy <= i_req.valid;
            r_fin  <= 1'b0;
            r_step <= '0;
        end else if (r_fin) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
        end else if (r_step == STEP_W'(HALF_STEPS - 1)) begin
            r_fin <= 1'b1;
        end else begin
            r_step <= r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req.valid) begin
            r_x   <= load_state(i_key, i_nonce, i_req.ctr);
            r_ctr <= i_req.ctr;
        end else if (r_busy && !r_fin) begin
            r_x <= n_round;
        end
    end

endmodule

FILE: sv/chacha_back.sv
// Output side: double keystream buffer, block requests, byte XOR and result register.
module chacha_back
    import chacha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_word      i_start_ctr,
    input  logic       i_rekey,
    input  logic       i_head_valid,
    input  t_qentry    i_head,
    output logic       o_head_pop,
    output t_ks_req    o_req,
    input  t_ks_status i_gen,
    input  t_block     i_block,
    input  logic       i_out_pop,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_active
);

    t_block     r_ks [2];
    logic [1:0] r_ks_valid;
    logic       r_rd_slot;
    logic       r_wr_slot;
    logic       r_active;
    logic       r_drop;
    t_word      r_next_ctr;
    t_word      r_rd_ctr;
    logic       r_rd_used;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    t_word      ks_word;
    logic [7:0] ks_byte;
    logic       out_ready;
    logic       fire;
    logic       start;
    logic       req_valid;
    logic       blk_end;

    always_comb begin
        ks_word   = r_ks[r_rd_slot][i_head.pos[5:2]];
        ks_byte   = ks_word[{i_head.pos[1:0], 3'b000} +: 8];
        out_ready = !r_out_valid || i_out_pop;
        fire      = i_head_valid && r_active && r_ks_valid[r_rd_slot] && out_ready;
        start     = i_head_valid && i_head.first && !r_active;
        req_valid = r_active && !i_gen.busy && !r_ks_valid[r_wr_slot];
        blk_end   = (i_head.pos == POS_W'(BLOCK_BYTES - 1));
    end

    assign o_head_pop  = fire;
    assign o_req.valid = req_valid;
    assign o_req.ctr   = r_next_ctr;
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;
    assign o_active    = r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ks_valid  <= '0;
            r_rd_slot   <= 1'b0;
            r_wr_slot   <= 1'b0;
            r_active    <= 1'b0;
            r_drop      <= 1'b0;
            r_next_ctr  <= '0;
            r_rd_ctr    <= '0;
            r_rd_used   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_gen.done) begin
                if (r_drop) begin
                    r_drop <= 1'b0;
                end else begin
                    r_ks_valid[r_wr_slot] <= 1'b1;
                    r_wr_slot             <= !r_wr_slot;
                end
            end
            if (req_valid) begin
                r_next_ctr <= r_next_ctr + 1'b1;
            end
            if (start) begin
                r_active   <= 1'b1;
                r_next_ctr <= i_start_ctr;
                r_rd_ctr   <= i_start_ctr;
                r_rd_used  <= 1'b0;
            end
            if (fire && !i_head.last && blk_end) begin
                r_ks_valid[r_rd_slot] <= 1'b0;
                r_rd_slot             <= !r_rd_slot;
                r_rd_ctr              <= r_rd_ctr + 1'b1;
                r_rd_used             <= 1'b0;
            end
            if (fire && !i_head.last && !blk_end) begin
                r_rd_used <= 1'b1;
            end
            // End of message: forget both buffers and any block still in flight,
            // including one requested in this very cycle.
            if (fire && i_head.last) begin
                r_active   <= 1'b0;
                r_ks_valid <= '0;
                r_rd_slot  <= 1'b0;
                r_wr_slot  <= 1'b0;
                r_rd_used  <= 1'b0;
                r_drop     <= (i_gen.busy && !i_gen.done) || req_valid;
            end
            // A key or nonce change inside a message keeps only the block that is
            // partly used and makes every later block again with the new values.
            if (i_rekey && r_active) begin
                if (r_rd_used) begin
                    r_ks_valid[!r_rd_slot] <= 1'b0;
                    r_wr_slot              <= !r_rd_slot;
                    r_next_ctr             <= r_rd_ctr + 1'b1;
                end else begin
                    r_ks_valid <= '0;
                    r_wr_slot  <= r_rd_slot;
                    r_next_ctr <= r_rd_ctr;
                end
                r_drop <= (i_gen.busy && !i_gen.done) || req_valid;
            end
            if (out_ready) begin
                r_out_valid <= fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_gen.done && !r_drop) begin
            r_ks[r_wr_slot] <= i_block;
        end
        if (fire) begin
            r_out_byte <= i_head.data ^ ks_byte;
            r_out_last <= i_head.last;
        end
    end

endmodule

FILE: sv/chacha20_stream_cipher_core.sv
// Top level of the ChaCha20 stream cipher core (RFC 8439 keystream XOR, byte stream).
//
// Channel   Dir  Handshake                   Payload
// input     in   push / full                 i_data_byte, i_last_byte
// result    out  empty / pop                 o_out_byte, o_out_last
// config    in   i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// Inside a message the core moves one byte per cycle unless it waits for keystream or
// for the result side: the keystream unit makes each block from a request through 40
// half-round steps and the final add, and works one block ahead into a second buffer.
// The first byte of each message waits at the queue head for block zero, and longer
// when a block for the previous message was still being computed and must be thrown
// away. A key or nonce write inside an open message discards the blocks made ahead,
// so the next block boundary waits for a fresh block. Reset is synchronous, active
// low, and clears all control state and the configuration registers. The byte queue
// of QUEUE_DEPTH entries and the result register let either side stall independently.
`include "chacha20_stream_cipher_core_defines.svh"

module chacha20_stream_cipher_core
    import chacha_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           o_out_byte,
    output logic                 o_out_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    // Configuration registers. The core accepts a write on every cycle; the user is
    // to make writes only while no byte is in flight (the core does not enforce
    // this), so the keystream unit can read key and nonce directly from here.
    t_key   r_key;
    t_nonce r_nonce;
    t_word  r_start_ctr;

    // A transfer to a key or nonce register.
    logic rekey;

    // Front part to queue.
    logic    q_wr;
    t_qentry q_wr_data;
    logic    q_full;

    // Queue to back part.
    logic    head_valid;
    t_qentry head;
    logic    head_pop;

    // Back part to keystream unit.
    t_ks_req    ks_req;
    t_ks_status ks_status;
    t_block     ks_block;

    logic out_valid;
    logic back_active;

    assign o_cfg_ready = 1'b1;
    assign rekey       = i_cfg_valid && o_cfg_ready && (i_cfg_index <= REG_NONCE_2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= '0;
            r_nonce     <= '0;
            r_start_ctr <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_KEY_01: begin
                    r_key[0] <= i_cfg_data[31:0];
                    r_key[1] <= i_cfg_data[63:32];
                end
                REG_KEY_23: begin
                    r_key[2] <= i_cfg_data[31:0];
                    r_key[3] <= i_cfg_data[63:32];
                end
                REG_KEY_45: begin
                    r_key[4] <= i_cfg_data[31:0];
                    r_key[5] <= i_cfg_data[63:32];
                end
                REG_KEY_67: begin
                    r_key[6] <= i_cfg_data[31:0];
                    r_key[7] <= i_cfg_data[63:32];
                end
                REG_NONCE_01: begin
                    r_nonce[0] <= i_cfg_data[31:0];
                    r_nonce[1] <= i_cfg_data[63:32];
                end
                REG_NONCE_2: begin
                    r_nonce[2] <= i_cfg_data[31:0];
                end
                REG_START_CTR: begin
                    r_start_ctr <= i_cfg_data[31:0];
                end
                default: begin
                    // Indexes past the register list are ignored.
                end
            endcase
        end
    end

    // The front part tags each byte with its place in the keystream block and
    // whether it opens a new message.
    chacha_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_data    (i_data_byte),
        .i_last    (i_last_byte),
        .i_q_full  (q_full),
        .o_wr      (q_wr),
        .o_wr_data (q_wr_data)
    );

    chacha_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (q_wr),
        .i_wr_data  (q_wr_data),
        .o_full     (q_full),
        .i_rd       (head_pop),
        .o_rd_valid (head_valid),
        .o_rd_data  (head)
    );

    // The keystream unit serves one block request at a time.
    chacha_keygen u_keygen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    (r_key),
        .i_nonce  (r_nonce),
        .i_req    (ks_req),
        .o_status (ks_status),
        .o_block  (ks_block)
    );

    // The back part loads the block counter at each message start, keeps two
    // keystream buffers and combines the queued bytes with the keystream.
    chacha_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start_ctr  (r_start_ctr),
        .i_rekey      (rekey),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_head_pop   (head_pop),
        .o_req        (ks_req),
        .i_gen        (ks_status),
        .i_block      (ks_block),
        .i_out_pop    (pop),
        .o_out_valid  (out_valid),
        .o_out_byte   (o_out_byte),
        .o_out_last   (o_out_last),
        .o_active     (back_active)
    );

    assign empty = !out_valid;

    // A new block is only requested from an idle keystream unit.
    `CHACHA_ASSERT_IMPL(a_req_when_idle, i_clk, i_rst_n, ks_req.valid, !ks_status.busy)
    // The unit frees itself right after delivering a block.
    `CHACHA_ASSERT_NEXT(a_done_then_idle, i_clk, i_rst_n, ks_status.done, !ks_status.busy)
    // A byte from the middle of a message always finds the back part inside that message.
    `CHACHA_ASSERT_IMPL(a_mid_msg_active, i_clk, i_rst_n, head_valid && !head.first,
                        back_active)
    // The back part never takes a byte from an empty queue.
    `CHACHA_ASSERT_IMPL(a_pop_has_data, i_clk, i_rst_n, head_pop, head_valid)

endmodule
